// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/tec_pkg.sv =====
package tec_pkg;

  // transaction kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  // slot number as reported on the result
  typedef logic [2:0] slot_t;

  // one input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_key;
    logic [31:0] ttl_value;
    logic [31:0] payload_handle;
    logic [31:0] elapsed_seconds;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic        hit;
    slot_t       hit_slot;
    logic [31:0] hit_payload;
    logic [31:0] hit_ttl;
    logic        replaced;
    slot_t       write_slot;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] ttl;
    logic [31:0] payload;
  } entry_t;

  // flags and value from the shared compare/subtract unit
  typedef struct packed {
    logic        ttl_zero;
    logic        key_eq;
    logic [31:0] ttl_sat;
  } unit_t;

endpackage

// ===== src/ttl_expiry_cache_table.sv =====
// TTL expiry cache table: CAPACITY records of key, remaining ttl and payload.
// Command channel: req_i is taken at a rising edge with start high and busy
// low; busy then stays high until the transaction is done. Result channel:
// done_o is high for exactly one cycle with rsp_o valid; the receiver cannot
// stall it, and the next command may be accepted in that same cycle.
// Insert scans the records oldest first for an expired one; lookup scans
// newest first for a live matching key; tick rewrites every ttl saturating
// at zero. The records sit in a single-port-read, single-port-write memory
// with registered read, walked one entry per cycle by the shared
// compare/subtract unit. An insert into a full table with nothing expired
// scans every record, shifts them all down one place and writes the new
// record last. Unknown kinds finish with an all-zero result. A new command
// is taken only once the last is done, since busy drops with done_o.
// Reset empties the table (fill count to zero); no clearing pass is needed.
module ttl_expiry_cache_table #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tec_pkg::req_t   req_i,
  output logic            done_o,
  output tec_pkg::rsp_t   rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   ridx_q, ridx_d;
  logic            rv_q, rv_d;
  logic            done_q, done_d;
  tec_pkg::rsp_t   rsp_q, rsp_d;
  tec_pkg::req_t   req_q;

  tec_pkg::entry_t mem [CAPACITY];
  tec_pkg::entry_t rd_q;
  tec_pkg::entry_t wdata, new_entry;
  logic            re, we;
  logic [IW-1:0]   raddr, waddr;
  logic [FW-1:0]   idx_dec;
  tec_pkg::unit_t  ures;

  // shared compare/subtract unit on the record just read
  tec_unit u_unit (
    .entry_i   (rd_q),
    .key_i     (req_q.name_key),
    .elapsed_i (req_q.elapsed_seconds),
    .res_o     (ures)
  );

  assign new_entry = '{key: req_q.name_key, ttl: req_q.ttl_value,
                       payload: req_q.payload_handle};
  assign idx_dec   = idx_q - FW'(1);

  // record memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // captured command
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    ridx_d  = ridx_q;
    rv_d    = 1'b0;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    re      = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = new_entry;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_RUN;
          idx_d   = (tec_pkg::kind_e'(req_i.kind) == tec_pkg::KIND_LOOKUP) ? fill_q : '0;
        end
      end

      S_RUN: begin
        case (tec_pkg::kind_e'(req_q.kind))
          tec_pkg::KIND_INSERT: begin
            if (rv_q && ures.ttl_zero) begin
              // reuse the oldest expired record
              we      = 1'b1;
              waddr   = ridx_q;
              rsp_d   = '0;
              rsp_d.replaced   = 1'b1;
              rsp_d.write_slot = tec_pkg::slot_t'(ridx_q);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (idx_q < fill_q) begin
              re     = 1'b1;
              raddr  = idx_q[IW-1:0];
              ridx_d = idx_q[IW-1:0];
              rv_d   = 1'b1;
              idx_d  = idx_q + FW'(1);
            end else if (!rv_q) begin
              if (fill_q == FW'(CAPACITY)) begin
                // full with nothing expired: shift everything down one
                state_d = S_SHIFT;
                idx_d   = FW'(1);
              end else begin
                // append
                we      = 1'b1;
                waddr   = fill_q[IW-1:0];
                rsp_d   = '0;
                rsp_d.write_slot = tec_pkg::slot_t'(fill_q);
                fill_d  = fill_q + FW'(1);
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
          end

          tec_pkg::KIND_LOOKUP: begin
            if (rv_q && ures.key_eq && !ures.ttl_zero) begin
              rsp_d   = '0;
              rsp_d.hit         = 1'b1;
              rsp_d.hit_slot    = tec_pkg::slot_t'(ridx_q);
              rsp_d.hit_payload = rd_q.payload;
              rsp_d.hit_ttl     = rd_q.ttl;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (idx_q != '0) begin
              re     = 1'b1;
              raddr  = idx_dec[IW-1:0];
              ridx_d = idx_dec[IW-1:0];
              rv_d   = 1'b1;
              idx_d  = idx_dec;
            end else if (!rv_q) begin
              rsp_d   = '0;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end

          tec_pkg::KIND_TICK: begin
            // write back the decremented ttl of the previous read
            if (rv_q) begin
              we    = 1'b1;
              waddr = ridx_q;
              wdata = '{key: rd_q.key, ttl: ures.ttl_sat, payload: rd_q.payload};
            end
            if (idx_q < fill_q) begin
              re     = 1'b1;
              raddr  = idx_q[IW-1:0];
              ridx_d = idx_q[IW-1:0];
              rv_d   = 1'b1;
              idx_d  = idx_q + FW'(1);
            end else if (!rv_q) begin
              rsp_d   = '0;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end

          default: begin
            rsp_d   = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_SHIFT: begin
        // copy record i+1 into i, then place the new record last
        if (rv_q) begin
          we    = 1'b1;
          waddr = ridx_q - IW'(1);
          wdata = rd_q;
        end
        if (idx_q < FW'(CAPACITY)) begin
          re     = 1'b1;
          raddr  = idx_q[IW-1:0];
          ridx_d = idx_q[IW-1:0];
          rv_d   = 1'b1;
          idx_d  = idx_q + FW'(1);
        end else if (!rv_q) begin
          we      = 1'b1;
          waddr   = IW'(CAPACITY - 1);
          rsp_d   = '0;
          rsp_d.replaced   = 1'b1;
          rsp_d.write_slot = tec_pkg::slot_t'(CAPACITY - 1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      ridx_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      ridx_q  <= ridx_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== src/tec_unit.sv =====
module tec_unit (
  input  tec_pkg::entry_t entry_i,
  input  logic [63:0]     key_i,
  input  logic [31:0]     elapsed_i,
  output tec_pkg::unit_t  res_o
);

  logic [32:0] diff;

  // saturating ttl decrement, borrow means the record expired
  assign diff = {1'b0, entry_i.ttl} - {1'b0, elapsed_i};

  always_comb begin
    res_o.ttl_zero = (entry_i.ttl == 32'd0);
    res_o.key_eq   = (entry_i.key == key_i);
    res_o.ttl_sat  = diff[32] ? 32'd0 : diff[31:0];
  end

endmodule

// ===== src/tec_checker.sv =====
`include "assert_macros.svh"

module tec_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input tec_pkg::rsp_t rsp_o
);

  // an accepted command makes the block busy
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // a result ends a busy period
  `ASSERT_IMPLY(a_done_ends_busy, clk_i, rst_ni, done_o, !busy && $past(busy))

  // one result per transaction, never two in a row
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // a hit carries a live ttl and no insert status
  `ASSERT_IMPLY(a_hit_live, clk_i, rst_ni, done_o && rsp_o.hit,
                rsp_o.hit_ttl != 32'd0 && !rsp_o.replaced)

  // without a hit the lookup fields stay clear
  `ASSERT_IMPLY(a_miss_clear, clk_i, rst_ni, done_o && !rsp_o.hit,
                rsp_o.hit_ttl == 32'd0 && rsp_o.hit_payload == 32'd0)

endmodule

bind ttl_expiry_cache_table tec_checker u_tec_checker (.*);
